// File: rtl/core/yuyv_to_i420_converter_core_macros.svh
// ----------------------------------------------------------------------------
// YUYV to I420 converter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_I420_CONVERTER_CORE_MACROS_SVH
`define YUYV_TO_I420_CONVERTER_CORE_MACROS_SVH

// The expression holds at every clock edge.
`define Y2I_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define Y2I_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define Y2I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/y2i_pkg.sv
// ----------------------------------------------------------------------------
// YUYV to I420 converter package
// Widths, codes, shared types and the frame size clamp function.
// ----------------------------------------------------------------------------
package y2i_pkg;

  localparam int SIZE_W    = 13;
  localparam int COUNT_W   = 12;
  localparam int LUMA_W    = 24;
  localparam int CHROMA_W  = 22;
  localparam int ADDR_W    = 25;
  localparam int BYTE_W    = 8;
  localparam int PLANE_W   = 2;
  localparam int STEP_W    = 2;
  localparam int INDEX_W   = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] MAX_WIDTH      = 13'd4096;
  localparam logic [SIZE_W-1:0] MAX_HEIGHT     = 13'd4096;
  localparam logic [SIZE_W-1:0] MIN_SIZE       = 13'd2;
  localparam logic [SIZE_W-1:0] RESET_WIDTH    = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT   = 13'd480;

  localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  localparam logic [STEP_W-1:0] STEP_Y0 = 2'd0;
  localparam logic [STEP_W-1:0] STEP_Y1 = 2'd1;
  localparam logic [STEP_W-1:0] STEP_U  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_V  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]   luma_first;
    logic [BYTE_W-1:0]   chroma_blue;
    logic [BYTE_W-1:0]   luma_second;
    logic [BYTE_W-1:0]   chroma_red;
    logic [LUMA_W-1:0]   luma_addr;
    logic [CHROMA_W-1:0] chroma_addr;
    logic                even_row;
    logic                frame_end;
  } y2i_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] u_base;
    logic [ADDR_W-1:0] v_base;
  } y2i_bases_t;

  function automatic logic [SIZE_W-1:0] y2i_eff_size(input logic [SIZE_W-1:0] raw,
                                                     input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] v;
    v = {raw[SIZE_W-1:1], 1'b0};
    if (v == '0) begin
      v = MIN_SIZE;
    end
    if (v > limit) begin
      v = {limit[SIZE_W-1:1], 1'b0};
    end
    if (v == '0) begin
      v = MIN_SIZE;
    end
    return v;
  endfunction

endpackage

// File: rtl/core/y2i_front.sv
// ----------------------------------------------------------------------------
// YUYV to I420 front end
// Holds the frame size, tracks the raster position and classifies each
// macropixel into a queue entry with its plane offsets and row flags.
// ----------------------------------------------------------------------------
`include "yuyv_to_i420_converter_core_macros.svh"

module y2i_front import y2i_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [INDEX_W-1:0]  cfg_index_i,
  input  logic [SIZE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [BYTE_W-1:0]   luma_first_i,
  input  logic [BYTE_W-1:0]   chroma_blue_i,
  input  logic [BYTE_W-1:0]   luma_second_i,
  input  logic [BYTE_W-1:0]   chroma_red_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output y2i_entry_t          q_entry_o,
  output y2i_bases_t          bases_o
);

  logic [SIZE_W-1:0]   width_q, width_d;
  logic [SIZE_W-1:0]   height_q, height_d;
  logic [ADDR_W-1:0]   luma_size_q;
  logic [ADDR_W-1:0]   v_base_q;
  logic [COUNT_W-1:0]  col_q, col_d;
  logic [COUNT_W-1:0]  row_q, row_d;
  logic [LUMA_W-1:0]   luma_q, luma_d;
  logic [CHROMA_W-1:0] chroma_q, chroma_d;
  logic [2*SIZE_W-1:0] product;
  logic                accept;
  logic                even_row;
  logic                row_end;
  logic                frame_end;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_d  = y2i_eff_size(cfg_wdata_i, MAX_WIDTH);
        REG_FRAME_HEIGHT: height_d = y2i_eff_size(cfg_wdata_i, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  assign product = width_q * height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RESET_WIDTH;
      height_q    <= RESET_HEIGHT;
      luma_size_q <= ADDR_W'(RESET_WIDTH * RESET_HEIGHT);
      v_base_q    <= ADDR_W'((RESET_WIDTH * RESET_HEIGHT * 5) / 4);
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      luma_size_q <= product[ADDR_W-1:0];
      v_base_q    <= luma_size_q + {2'b00, luma_size_q[ADDR_W-1:2]};
    end
  end

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;

  assign even_row  = !row_q[0];
  assign row_end   = ({1'b0, col_q} + SIZE_W'(2)) >= width_q;
  assign frame_end = row_end && (({1'b0, row_q} + SIZE_W'(1)) >= height_q);

  always_comb begin
    q_entry_o.luma_first  = luma_first_i;
    q_entry_o.chroma_blue = chroma_blue_i;
    q_entry_o.luma_second = luma_second_i;
    q_entry_o.chroma_red  = chroma_red_i;
    q_entry_o.luma_addr   = luma_q;
    q_entry_o.chroma_addr = chroma_q;
    q_entry_o.even_row    = even_row;
    q_entry_o.frame_end   = frame_end;
  end

  assign bases_o.u_base = luma_size_q;
  assign bases_o.v_base = v_base_q;

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    luma_d   = luma_q;
    chroma_d = chroma_q;
    if (accept) begin
      if (frame_end) begin
        col_d    = '0;
        row_d    = '0;
        luma_d   = '0;
        chroma_d = '0;
      end else begin
        luma_d = luma_q + LUMA_W'(2);
        if (even_row) begin
          chroma_d = chroma_q + CHROMA_W'(1);
        end
        if (row_end) begin
          col_d = '0;
          row_d = row_q + COUNT_W'(1);
        end else begin
          col_d = col_q + COUNT_W'(2);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      luma_q   <= '0;
      chroma_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      luma_q   <= luma_d;
      chroma_q <= chroma_d;
    end
  end

  `Y2I_ASSERT_NEXT(a_frame_wrap, accept && frame_end, col_q == '0 && row_q == '0 && luma_q == '0 && chroma_q == '0, "Position did not wrap at the end of the frame.")

endmodule

// File: rtl/core/y2i_queue.sv
// ----------------------------------------------------------------------------
// YUYV to I420 entry queue
// Short first-in first-out queue of classified macropixels between the
// front end and the write sequencer.
// ----------------------------------------------------------------------------
`include "yuyv_to_i420_converter_core_macros.svh"

module y2i_queue import y2i_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  y2i_entry_t  push_entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output y2i_entry_t  head_o
);

  y2i_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `Y2I_ASSERT_ALWAYS(a_count_range, count_q <= QCNT_W'(QUEUE_DEPTH), "Queue occupancy exceeds its depth.")

endmodule

// File: rtl/core/y2i_back.sv
// ----------------------------------------------------------------------------
// YUYV to I420 write sequencer
// Walks the head queue entry one byte write per cycle while not stalled, into a
// registered output stage: two luma writes, then U and V on even rows.
// ----------------------------------------------------------------------------
`include "yuyv_to_i420_converter_core_macros.svh"

module y2i_back import y2i_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  y2i_entry_t          q_head_i,
  output logic                q_pop_o,
  input  y2i_bases_t          bases_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PLANE_W-1:0]  plane_select_o,
  output logic [ADDR_W-1:0]   write_address_o,
  output logic [BYTE_W-1:0]   write_data_o,
  output logic                last_of_run_o,
  output logic                frame_done_o
);

  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [BYTE_W-1:0]  data_q, data_d;
  logic               last_q, last_d;
  logic               done_q, done_d;
  logic               out_free;
  logic               load;
  logic               final_step;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = q_valid_i && out_free;

  always_comb begin
    plane_d    = PLANE_Y;
    addr_d     = {1'b0, q_head_i.luma_addr};
    data_d     = q_head_i.luma_first;
    last_d     = 1'b0;
    done_d     = 1'b0;
    final_step = 1'b0;
    unique case (step_q)
      STEP_Y0: begin
      end
      STEP_Y1: begin
        addr_d     = {1'b0, q_head_i.luma_addr} + ADDR_W'(1);
        data_d     = q_head_i.luma_second;
        last_d     = !q_head_i.even_row;
        done_d     = !q_head_i.even_row && q_head_i.frame_end;
        final_step = !q_head_i.even_row;
      end
      STEP_U: begin
        plane_d = PLANE_U;
        addr_d  = bases_i.u_base + ADDR_W'(q_head_i.chroma_addr);
        data_d  = q_head_i.chroma_blue;
      end
      STEP_V: begin
        plane_d    = PLANE_V;
        addr_d     = bases_i.v_base + ADDR_W'(q_head_i.chroma_addr);
        data_d     = q_head_i.chroma_red;
        last_d     = 1'b1;
        done_d     = q_head_i.frame_end;
        final_step = 1'b1;
      end
      default: ;
    endcase
  end

  assign q_pop_o = load && final_step;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = final_step ? STEP_Y0 : step_q + STEP_W'(1);
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_Y0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plane_q <= plane_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
      last_q  <= last_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign plane_select_o  = plane_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;
  assign last_of_run_o   = last_q;
  assign frame_done_o    = done_q;

  `Y2I_ASSERT_IMPL(a_done_is_last, out_valid_q && done_q, last_q, "Frame end flagged on a write that does not end its macropixel.")
  `Y2I_ASSERT_IMPL(a_plane_code, out_valid_q, plane_q == PLANE_Y || plane_q == PLANE_U || plane_q == PLANE_V, "Write carries an undefined plane code.")
  `Y2I_ASSERT_IMPL(a_mid_item_head, step_q != STEP_Y0, q_valid_i, "Sequencer is inside a macropixel with no queue entry.")

endmodule

// File: rtl/core/yuyv_to_i420_converter_core.sv
// ----------------------------------------------------------------------------
// YUYV to I420 converter core
// Converts packed YUYV 4:2:2 macropixels into byte writes of an I420 frame.
// ----------------------------------------------------------------------------
// Each accepted macropixel produces two luma writes, plus one U and one V
// write on even rows, issued one write per cycle while the output is not
// stalled, on the registered output stage of the write sequencer. Input
// transactions are classified and taken without waiting on the output, into a
// two-entry queue, so while the queue has room a new macropixel can be
// accepted in the cycle after the previous one. The frame size is taken from
// the configuration registers with bit 0 cleared, zero treated as two and
// larger values clamped to 4096; write them only while no transaction is in
// flight.

module yuyv_to_i420_converter_core import y2i_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [INDEX_W-1:0]  cfg_index_i,
  input  logic [SIZE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [BYTE_W-1:0]   luma_first_i,
  input  logic [BYTE_W-1:0]   chroma_blue_i,
  input  logic [BYTE_W-1:0]   luma_second_i,
  input  logic [BYTE_W-1:0]   chroma_red_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PLANE_W-1:0]  plane_select_o,
  output logic [ADDR_W-1:0]   write_address_o,
  output logic [BYTE_W-1:0]   write_data_o,
  output logic                last_of_run_o,
  output logic                frame_done_o
);

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  y2i_entry_t  q_entry;
  y2i_entry_t  q_head;
  y2i_bases_t  bases;

  y2i_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_entry),
    .bases_o       (bases)
  );

  y2i_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  y2i_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .bases_i         (bases),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .plane_select_o  (plane_select_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .last_of_run_o   (last_of_run_o),
    .frame_done_o    (frame_done_o)
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// YUYV to I420 converter testbench
// Feeds macropixel transactions and frame sizes into the converter core and
// checks every byte write, in order, against a model of the I420 frame layout.
// ----------------------------------------------------------------------------
module tb;
  import y2i_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 250;
  localparam int MAX_REPORTS = 60;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               done;
  } write_t;

  typedef struct packed {
    row_kind_e                kind;
    logic [INDEX_W-1:0]       reg_index;
    logic [SIZE_W-1:0]        reg_value;
    logic [BYTE_W-1:0]        y0;
    logic [BYTE_W-1:0]        cb;
    logic [BYTE_W-1:0]        y1;
    logic [BYTE_W-1:0]        cr;
    logic [2:0]               typed_n;
    logic [0:3][ADDR_W-1:0]   addrs;
    logic                     done;
  } row_t;

  localparam row_t DIRECTED_ROWS [26] = '{
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd4,
      '{25'd0, 25'd1, 25'd307200, 25'd384000}, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 13'd1, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'hA5, 8'h5A, 8'h3C, 8'hC3, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h5A, 8'hA5, 8'hC3, 8'h3C, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h01, 8'h02, 8'h04, 8'h08, 3'd4,
      '{25'd0, 25'd1, 25'd4, 25'd5}, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h10, 8'h20, 8'h40, 8'h80, 3'd2,
      '{25'd2, 25'd3, 25'd0, 25'd0}, 1'b1},
    '{ROW_CFG, REG_FRAME_WIDTH, 13'd8191, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 13'd4097, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h7F, 8'h80, 8'hFE, 8'h01, 3'd4,
      '{25'd0, 25'd1, 25'd16777216, 25'd20971520}, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h12, 8'h34, 8'h56, 8'h78, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_WIDTH, 13'd1, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 13'd3, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h0F, 8'hE1, 8'h2D, 8'h4B, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_WIDTH, 13'd6, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 13'd4, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h11, 8'h22, 8'h33, 8'h44, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h80, 8'h7F, 8'h01, 8'hFE, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'hC0, 8'h3F, 8'h0F, 8'hF0, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h96, 8'h69, 8'hAA, 8'h55, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h55, 8'hAA, 8'h69, 8'h96, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'hE7, 8'h18, 8'h24, 8'hDB, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h02, 8'h04, 8'h08, 8'h10, 3'd0, '0, 1'b0},
    '{ROW_ITEM, REG_FRAME_WIDTH, 13'd0, 8'h20, 8'h40, 8'h80, 8'h01, 3'd0, '0, 1'b0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [INDEX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [BYTE_W-1:0]  luma_first_i = '0;
  logic [BYTE_W-1:0]  chroma_blue_i = '0;
  logic [BYTE_W-1:0]  luma_second_i = '0;
  logic [BYTE_W-1:0]  chroma_red_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PLANE_W-1:0] plane_select_o;
  logic [ADDR_W-1:0]  write_address_o;
  logic [BYTE_W-1:0]  write_data_o;
  logic               last_of_run_o;
  logic               frame_done_o;

  // Frame layout model state.
  logic [SIZE_W-1:0]   frame_w = RESET_WIDTH;
  logic [SIZE_W-1:0]   frame_h = RESET_HEIGHT;
  logic [COUNT_W-1:0]  col_pos = '0;
  logic [COUNT_W-1:0]  row_pos = '0;
  logic [LUMA_W-1:0]   luma_pos = '0;
  logic [CHROMA_W-1:0] chroma_pos = '0;

  write_t pending_writes [$];
  write_t want;
  int     mismatches = 0;
  int     cycle_count = 0;
  int     hold_left = 0;
  bit     hold_req = 1'b0;
  bit     steady = 1'b0;

  yuyv_to_i420_converter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .plane_select_o (plane_select_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic write_t mk_write(input logic [PLANE_W-1:0] p, input logic [ADDR_W-1:0] a,
                                      input logic [BYTE_W-1:0] d, input logic l, input logic f);
    write_t wr;
    wr.plane = p;
    wr.addr = a;
    wr.data = d;
    wr.last = l;
    wr.done = f;
    return wr;
  endfunction

  function automatic int unsigned usable_size(input logic [SIZE_W-1:0] raw,
                                              input int unsigned cap);
    int unsigned s;
    s = raw & ~32'd1;
    if (s == 0) begin
      s = 2;
    end
    if (s > cap) begin
      s = cap & ~32'd1;
    end
    if (s == 0) begin
      s = 2;
    end
    return s;
  endfunction

  task automatic convert_macropixel(input logic [BYTE_W-1:0] y0, cb, y1, cr,
                                    output write_t res [4], output int n);
    int unsigned       w;
    int unsigned       h;
    logic [ADDR_W-1:0] luma_size;
    logic [ADDR_W-1:0] v_base;
    logic [ADDR_W-1:0] y_addr;
    logic              row_end;
    logic              frame_end;
    w = usable_size(frame_w, MAX_WIDTH);
    h = usable_size(frame_h, MAX_HEIGHT);
    luma_size = ADDR_W'(w * h);
    v_base = luma_size + luma_size / 4;
    y_addr = ADDR_W'(luma_pos);
    row_end = (32'(col_pos) + 2 >= w);
    frame_end = row_end && (32'(row_pos) + 1 >= h);
    res[0] = mk_write(PLANE_Y, y_addr, y0, 1'b0, 1'b0);
    if (!row_pos[0]) begin
      res[1] = mk_write(PLANE_Y, y_addr + 1'b1, y1, 1'b0, 1'b0);
      res[2] = mk_write(PLANE_U, luma_size + ADDR_W'(chroma_pos), cb, 1'b0, 1'b0);
      res[3] = mk_write(PLANE_V, v_base + ADDR_W'(chroma_pos), cr, 1'b1, frame_end);
      n = 4;
      chroma_pos = chroma_pos + 1'b1;
    end else begin
      res[1] = mk_write(PLANE_Y, y_addr + 1'b1, y1, 1'b1, frame_end);
      n = 2;
    end
    if (frame_end) begin
      col_pos = '0;
      row_pos = '0;
      luma_pos = '0;
      chroma_pos = '0;
    end else begin
      luma_pos = luma_pos + 2'd2;
      if (row_end) begin
        col_pos = '0;
        row_pos = row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 2'd2;
      end
    end
  endtask

  task automatic send_row(input row_t r);
    write_t res [4];
    int     n;
    int     gap;
    if (!steady && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    luma_first_i <= r.y0;
    chroma_blue_i <= r.cb;
    luma_second_i <= r.y1;
    chroma_red_i <= r.cr;
    do @(posedge clk_i); while (in_stall_o);
    convert_macropixel(r.y0, r.cb, r.y1, r.cr, res, n);
    if (r.typed_n == 3'd2) begin
      pending_writes.push_back(mk_write(PLANE_Y, r.addrs[0], r.y0, 1'b0, 1'b0));
      pending_writes.push_back(mk_write(PLANE_Y, r.addrs[1], r.y1, 1'b1, r.done));
    end else if (r.typed_n == 3'd4) begin
      pending_writes.push_back(mk_write(PLANE_Y, r.addrs[0], r.y0, 1'b0, 1'b0));
      pending_writes.push_back(mk_write(PLANE_Y, r.addrs[1], r.y1, 1'b0, 1'b0));
      pending_writes.push_back(mk_write(PLANE_U, r.addrs[2], r.cb, 1'b0, 1'b0));
      pending_writes.push_back(mk_write(PLANE_V, r.addrs[3], r.cr, 1'b1, r.done));
    end else begin
      for (int k = 0; k < n; k++) begin
        pending_writes.push_back(res[k]);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) begin
      frame_w = val;
    end else begin
      frame_h = val;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return SIZE_W'($urandom_range(1, 8) * 2);
    end else if (r < 80) begin
      return SIZE_W'($urandom_range(0, 8) * 2 + 1);
    end else if (r < 88) begin
      return SIZE_W'($urandom_range(0, 1));
    end
    return SIZE_W'($urandom_range(0, 8191));
  endfunction

  // Write port back-pressure, with one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 32);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_writes.size() == 0) begin
        report($sformatf("write to address %0d with no transaction pending", write_address_o));
      end else begin
        want = pending_writes.pop_front();
        if (plane_select_o !== want.plane) begin
          report($sformatf("plane %0d, expected %0d (address %0d)",
                           plane_select_o, want.plane, want.addr));
        end
        if (write_address_o !== want.addr) begin
          report($sformatf("address %0d, expected %0d", write_address_o, want.addr));
        end
        if (write_data_o !== want.data) begin
          report($sformatf("data %02h, expected %02h (address %0d)",
                           write_data_o, want.data, want.addr));
        end
        if (last_of_run_o !== want.last) begin
          report($sformatf("last_of_run %0b, expected %0b (address %0d)",
                           last_of_run_o, want.last, want.addr));
        end
        if (frame_done_o !== want.done) begin
          report($sformatf("frame_done %0b, expected %0b (address %0d)",
                           frame_done_o, want.done, want.addr));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t r;
    int   sent;
    int   phase;
    int   count;
    int   which;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].reg_value);
      end else begin
        send_row(DIRECTED_ROWS[i]);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      which = $urandom_range(2);
      if (which != 1) begin
        write_reg(REG_FRAME_WIDTH, pick_size());
      end
      if (which != 0) begin
        write_reg(REG_FRAME_HEIGHT, pick_size());
      end
      steady = (phase == 3);
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      count = (phase == 1) ? 40 : $urandom_range(6, 40);
      repeat (count) begin
        r = '0;
        r.kind = ROW_ITEM;
        r.y0 = BYTE_W'($urandom_range(0, 255));
        r.cb = BYTE_W'($urandom_range(0, 255));
        r.y1 = BYTE_W'($urandom_range(0, 255));
        r.cr = BYTE_W'($urandom_range(0, 255));
        send_row(r);
        sent++;
      end
      steady = 1'b0;
      phase++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
